/* rtl/xtbc_pkg.sv */
// xtbc_pkg: shared types and constants for the xtea pipeline
// used by xtbc_stage and the top level; no dependencies
`default_nettype none

package xtbc_pkg;

    localparam logic [31:0] XT_DELTA = 32'h9E3779B9;

    typedef logic [3:0][31:0] t_keys;

    typedef struct packed {
        logic        mode;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_blk;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam int REG_KEY0 = 0;
    localparam int REG_KEY1 = 1;
    localparam int REG_KEY2 = 2;
    localparam int REG_KEY3 = 3;

    // running sum after n delta steps, modulo 2^32
    function automatic logic [31:0] xt_sum(input int n);
        logic [63:0] prod;
        prod = 64'(n) * 64'(XT_DELTA);
        return prod[31:0];
    endfunction

    function automatic logic [31:0] xt_mix(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

endpackage

`default_nettype wire

/* rtl/xtea_block_cipher_12_round_top.sv */
// one half round per stage, each stage holding its block in a pipeline register
// throughput: one block per cycle unless o_valid && !i_ready stalls the pipe; each stage holds one block
// reset: synchronous active low, clears stage valid bits and the key registers to zero
// xtea_block_cipher_12_round_top: apb key registers and the unrolled round pipeline
// depends on xtbc_pkg and xtbc_stage
`default_nettype none

module xtea_block_cipher_12_round_top #(
    parameter int ROUNDS = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_mode,
    input  wire  [31:0] i_block_lo,
    input  wire  [31:0] i_block_hi,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_out_lo,
    output logic [31:0] o_out_hi
);

    localparam int STAGES = 2 * ROUNDS;

    xtbc_pkg::t_keys r_keys;
    xtbc_pkg::t_blk  w_blk   [0:STAGES];
    logic            w_valid [0:STAGES];
    logic            w_ready [0:STAGES];

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= '0;
        end else if (psel && penable && pwrite) begin
            r_keys[paddr[3:2]] <= pwdata;
        end
    end

    always_comb begin
        unique case (int'(paddr[3:2]))
            xtbc_pkg::REG_KEY0: prdata = r_keys[0];
            xtbc_pkg::REG_KEY1: prdata = r_keys[1];
            xtbc_pkg::REG_KEY2: prdata = r_keys[2];
            xtbc_pkg::REG_KEY3: prdata = r_keys[3];
            default:            prdata = '0;
        endcase
    end

    assign w_blk[0].mode = i_mode;
    assign w_blk[0].lo   = i_block_lo;
    assign w_blk[0].hi   = i_block_hi;
    assign w_valid[0]    = i_valid;
    assign o_ready       = w_ready[0];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            localparam int RND = k / 2;
            localparam bit ODD = (k % 2) == 1;
            localparam logic [31:0] S_ENC = xtbc_pkg::xt_sum(ODD ? RND + 1 : RND);
            localparam logic [31:0] S_DEC =
                xtbc_pkg::xt_sum(ODD ? ROUNDS - RND - 1 : ROUNDS - RND);

            xtbc_stage #(
                .ODD_STEP (ODD),
                .SUM_ENC  (S_ENC),
                .SUM_DEC  (S_DEC)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_keys  (r_keys),
                .i_valid (w_valid[k]),
                .o_ready (w_ready[k]),
                .i_blk   (w_blk[k]),
                .o_valid (w_valid[k+1]),
                .i_ready (w_ready[k+1]),
                .o_blk   (w_blk[k+1])
            );
        end
    endgenerate

    assign w_ready[STAGES] = i_ready;
    assign o_valid         = w_valid[STAGES];
    assign o_out_lo        = w_blk[STAGES].lo;
    assign o_out_hi        = w_blk[STAGES].hi;

endmodule

`default_nettype wire

/* rtl/xtbc_stage.sv */
// xtbc_stage: one xtea half round with its pipeline register and stall control
// depends on xtbc_pkg
`default_nettype none

module xtbc_stage #(
    parameter bit          ODD_STEP = 1'b0,
    parameter logic [31:0] SUM_ENC  = 32'h0,
    parameter logic [31:0] SUM_DEC  = 32'h0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire xtbc_pkg::t_keys i_keys,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire xtbc_pkg::t_blk i_blk,
    output logic                o_valid,
    input  wire                 i_ready,
    output xtbc_pkg::t_blk      o_blk
);

    logic           r_valid;
    xtbc_pkg::t_blk r_blk;
    xtbc_pkg::t_blk n_blk;

    logic        w_hi_side;
    logic [31:0] w_sum;
    logic [1:0]  w_kidx;
    logic [31:0] w_src;
    logic [31:0] w_dst;
    logic [31:0] w_f;
    logic [31:0] w_res;

    // encipher even steps update lo from hi with the low key index;
    // decipher runs the same steps mirrored
    assign w_hi_side = ODD_STEP ^ (i_blk.mode == xtbc_pkg::MODE_DEC);
    assign w_sum     = (i_blk.mode == xtbc_pkg::MODE_DEC) ? SUM_DEC : SUM_ENC;
    assign w_kidx    = w_hi_side ? w_sum[12:11] : w_sum[1:0];
    assign w_src     = w_hi_side ? i_blk.lo : i_blk.hi;
    assign w_dst     = w_hi_side ? i_blk.hi : i_blk.lo;
    assign w_f       = xtbc_pkg::xt_mix(w_src) ^ (w_sum + i_keys[w_kidx]);
    assign w_res     = (i_blk.mode == xtbc_pkg::MODE_DEC) ? (w_dst - w_f) : (w_dst + w_f);

    always_comb begin
        n_blk = i_blk;
        if (w_hi_side) begin
            n_blk.hi = w_res;
        end else begin
            n_blk.lo = w_res;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_blk <= n_blk;
        end
    end

    assign o_valid = r_valid;
    assign o_blk   = r_blk;

endmodule

`default_nettype wire

/* rtl/xtbc_checker.sv */
// xtbc_checker: port-level assertions for the xtea pipeline, bound to the top level
// depends only on the top level's ports
`default_nettype none

module xtbc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        pready,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [31:0] o_out_lo,
    input wire [31:0] o_out_hi
);

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // an empty or draining output stage means the whole pipe can take a transaction
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("pipeline not ready while output flows");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_lo) && $stable(o_out_hi)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind xtea_block_cipher_12_round_top xtbc_checker u_xtbc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .pready   (pready),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_out_lo (o_out_lo),
    .o_out_hi (o_out_hi)
);

`default_nettype wire

/* dv/xtea_block_cipher_12_round_top_test.sv */
// self-checking testbench for xtea_block_cipher_12_round_top: apb key writes, directed and
// random blocks in both modes, results checked in order against an in-bench cipher predictor
// depends on xtbc_pkg and the top level rtl
module xtea_block_cipher_12_round_top_test;

    localparam int ROUNDS = 12;
    localparam int SETTLE_CYCLES = 2 * ROUNDS + 8;

    class cipher_scoreboard;
        logic [31:0] key [4];
        logic [31:0] exp_lo_q [$];
        logic [31:0] exp_hi_q [$];
        int errors;

        function new();
            for (int k = 0; k < 4; k++) key[k] = '0;
            errors = 0;
        endfunction

        function logic [31:0] feistel_mix(logic [31:0] x);
            return ((x << 4) ^ (x >> 5)) + x;
        endfunction

        // returns {lo, hi} after the full round count
        function logic [63:0] transform(logic m, logic [31:0] lo, logic [31:0] hi);
            logic [31:0] v0;
            logic [31:0] v1;
            logic [31:0] sum;
            v0 = lo;
            v1 = hi;
            if (m == xtbc_pkg::MODE_DEC) begin
                sum = xtbc_pkg::XT_DELTA * 32'(ROUNDS);
                for (int r = 0; r < ROUNDS; r++) begin
                    v1 = v1 - (feistel_mix(v0) ^ (sum + key[sum[12:11]]));
                    sum = sum - xtbc_pkg::XT_DELTA;
                    v0 = v0 - (feistel_mix(v1) ^ (sum + key[sum[1:0]]));
                end
            end else begin
                sum = '0;
                for (int r = 0; r < ROUNDS; r++) begin
                    v0 = v0 + (feistel_mix(v1) ^ (sum + key[sum[1:0]]));
                    sum = sum + xtbc_pkg::XT_DELTA;
                    v1 = v1 + (feistel_mix(v0) ^ (sum + key[sum[12:11]]));
                end
            end
            return {v0, v1};
        endfunction

        function void note_block(logic m, logic [31:0] lo, logic [31:0] hi);
            logic [63:0] res;
            res = transform(m, lo, hi);
            exp_lo_q.push_back(res[63:32]);
            exp_hi_q.push_back(res[31:0]);
        endfunction

        function void check_block(logic [31:0] lo, logic [31:0] hi);
            logic [31:0] want_lo;
            logic [31:0] want_hi;
            if (exp_lo_q.size() == 0) begin
                $error("unexpected result: out_lo %h out_hi %h", lo, hi);
                errors++;
                return;
            end
            want_lo = exp_lo_q.pop_front();
            want_hi = exp_hi_q.pop_front();
            if (lo !== want_lo) begin
                $error("out_lo: expected %h, actual %h", want_lo, lo);
                errors++;
            end
            if (hi !== want_hi) begin
                $error("out_hi: expected %h, actual %h", want_hi, hi);
                errors++;
            end
        endfunction

        function int pending();
            return exp_lo_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [31:0] i_block_lo;
    logic [31:0] i_block_hi;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_out_lo;
    logic [31:0] o_out_hi;

    logic quiet_run;
    cipher_scoreboard sb;

    xtea_block_cipher_12_round_top #(.ROUNDS(ROUNDS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_block_lo (i_block_lo),
        .i_block_hi (i_block_hi),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_lo   (o_out_lo),
        .o_out_hi   (o_out_hi)
    );

    always #10 i_clk = ~i_clk;

    // monitor both channels and drive the result-side ready
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_block(i_mode, i_block_lo, i_block_hi);
        if (i_rst_n && o_valid && i_ready) sb.check_block(o_out_lo, o_out_hi);
        i_ready <= quiet_run || ($urandom_range(99) >= 8);
    end

    initial begin
        #4_000_000;
        $display("xtea_block_cipher_12_round_top_test: errors");
        $finish;
    end

    // called at a rising edge; returns at the edge where the transaction is accepted
    task automatic send_block(input logic m, input logic [31:0] lo, input logic [31:0] hi);
        while (!quiet_run && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= m;
        i_block_lo <= lo;
        i_block_hi <= hi;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * idx);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.key[idx] = val;
    endtask

    task automatic set_keys(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        write_key(xtbc_pkg::REG_KEY0, k0);
        write_key(xtbc_pkg::REG_KEY1, k1);
        write_key(xtbc_pkg::REG_KEY2, k2);
        write_key(xtbc_pkg::REG_KEY3, k3);
    endtask

    task automatic edge_blocks();
        send_block(xtbc_pkg::MODE_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(xtbc_pkg::MODE_DEC, 32'h0000_0000, 32'h0000_0000);
        send_block(xtbc_pkg::MODE_ENC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(xtbc_pkg::MODE_DEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(xtbc_pkg::MODE_ENC, 32'h8000_0000, 32'h0000_0001);
        send_block(xtbc_pkg::MODE_DEC, 32'h0000_0001, 32'h8000_0000);
        send_block(xtbc_pkg::MODE_ENC, 32'hAAAA_AAAA, 32'h5555_5555);
        send_block(xtbc_pkg::MODE_DEC, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(99);
        if (sel < 4) return 32'h0000_0000;
        if (sel < 8) return 32'hFFFF_FFFF;
        if (sel < 10) return 32'h8000_0000 >> $urandom_range(31);
        return $urandom();
    endfunction

    task automatic random_blocks(input int count);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] ct;
        int n;
        n = 0;
        while (n < count) begin
            lo = pick_word();
            hi = pick_word();
            if ($urandom_range(99) < 10) begin
                // encipher, then decipher the predicted ciphertext as the next block sent
                ct = sb.transform(xtbc_pkg::MODE_ENC, lo, hi);
                send_block(xtbc_pkg::MODE_ENC, lo, hi);
                send_block(xtbc_pkg::MODE_DEC, ct[63:32], ct[31:0]);
                n += 2;
            end else begin
                send_block(1'($urandom_range(1)), lo, hi);
                n++;
            end
            if (n == count / 2 && $urandom_range(1) == 1) settle();
        end
    endtask

    initial begin
        sb = new();
        quiet_run  = 1'b0;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_valid    <= 1'b0;
        i_mode     <= xtbc_pkg::MODE_ENC;
        i_block_lo <= '0;
        i_block_hi <= '0;
        i_ready    <= 1'b1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // keys at their reset value of zero
        edge_blocks();
        settle();
        set_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        edge_blocks();
        send_block(xtbc_pkg::MODE_ENC, 32'h0123_4567, 32'h89AB_CDEF);
        send_block(xtbc_pkg::MODE_DEC, 32'h0123_4567, 32'h89AB_CDEF);

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            case (phase)
                0: begin
                    set_keys(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
                end
                1: begin
                    set_keys(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
                end
                default: begin
                    set_keys($urandom(), $urandom(), $urandom(), $urandom());
                end
            endcase
            quiet_run = (phase == 3);
            random_blocks(275);
            // after phase 2 the sender holds off until the pipeline has drained
            if (phase == 2) settle();
        end
        quiet_run = 1'b0;

        settle();
        if (sb.errors == 0) begin
            $display("xtea_block_cipher_12_round_top_test: clean");
        end else begin
            $display("xtea_block_cipher_12_round_top_test: errors");
        end
        $finish;
    end

endmodule
